/* hdl/utp_pkg.sv */
// Shared types, constants and the hex decode function for the UUID text parser.
package utp_pkg;

	localparam int unsigned POS_W  = 6;
	localparam int unsigned HALF_W = 64;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	// Form codes
	localparam logic [1:0] FORM_UNKNOWN = 2'd0;
	localparam logic [1:0] FORM_PLAIN   = 2'd1;
	localparam logic [1:0] FORM_HYPHEN  = 2'd2;
	localparam logic [1:0] FORM_BRACED  = 2'd3;

	// Accepted lengths
	localparam logic [POS_W:0] LEN_PLAIN  = 7'd32;
	localparam logic [POS_W:0] LEN_HYPHEN = 7'd36;
	localparam logic [POS_W:0] LEN_BRACED = 7'd38;

	// Places in the hyphen body, and of the closing brace
	localparam logic [POS_W-1:0] POS_DECIDE  = 6'd8;
	localparam logic [POS_W-1:0] POS_HYPH_1  = 6'd8;
	localparam logic [POS_W-1:0] POS_HYPH_2  = 6'd13;
	localparam logic [POS_W-1:0] POS_HYPH_3  = 6'd18;
	localparam logic [POS_W-1:0] POS_HYPH_4  = 6'd23;
	localparam logic [POS_W-1:0] POS_RBRACE  = 6'd37;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_t;

	typedef struct packed {
		logic [HALF_W-1:0] uuid_high;
		logic [HALF_W-1:0] uuid_low;
		logic              valid_res;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [1:0]        form;
		logic              failed;
		logic [HALF_W-1:0] acc_high;
		logic [HALF_W-1:0] acc_low;
	} parse_state_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(logic [7:0] c);
		hex_t h;
		h.is_hex = 1'b1;
		h.value  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = 4'(c - 8'h57);
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage

/* hdl/utp_stream_if.sv */
// Valid/ready stream channel carrying one payload of a chosen type.
interface utp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/utp_step.sv */
// Per-character form check, digit accumulation and end-of-string verdict.
module utp_step (
	input  utp_pkg::parse_state_t cur,
	input  utp_pkg::char_t        chr,
	output utp_pkg::parse_state_t nxt,
	output utp_pkg::result_t      res
);

	utp_pkg::hex_t              hx;
	logic                       do_shift;
	logic                       set_fail;
	logic                       body_chk;
	logic [utp_pkg::POS_W-1:0]  q;
	logic [utp_pkg::POS_W:0]    len;
	logic                       len_ok;
	logic                       ok;
	utp_pkg::parse_state_t      upd;

	assign hx  = utp_pkg::hex_decode(chr.ch);
	assign len = {1'b0, cur.pos} + 7'd1;

	always_comb begin
		do_shift = 1'b0;
		set_fail = 1'b0;
		body_chk = 1'b0;
		upd      = cur;
		q        = (cur.form == utp_pkg::FORM_BRACED) ? cur.pos - 6'd1 : cur.pos;

		if (!cur.failed) begin
			unique case (cur.form)
				utp_pkg::FORM_UNKNOWN: begin
					if (cur.pos == '0 && chr.ch == utp_pkg::CH_LBRACE) begin
						upd.form = utp_pkg::FORM_BRACED;
					end else if (cur.pos == utp_pkg::POS_DECIDE && chr.ch == utp_pkg::CH_HYPHEN) begin
						upd.form = utp_pkg::FORM_HYPHEN;
					end else if (!hx.is_hex) begin
						set_fail = 1'b1;
					end else begin
						if (cur.pos == utp_pkg::POS_DECIDE) upd.form = utp_pkg::FORM_PLAIN;
						do_shift = 1'b1;
					end
				end
				utp_pkg::FORM_PLAIN: begin
					if (cur.pos >= utp_pkg::LEN_PLAIN[utp_pkg::POS_W-1:0] || !hx.is_hex)
						set_fail = 1'b1;
					else
						do_shift = 1'b1;
				end
				utp_pkg::FORM_HYPHEN: begin
					body_chk = 1'b1;
				end
				utp_pkg::FORM_BRACED: begin
					if (cur.pos == utp_pkg::POS_RBRACE) begin
						if (chr.ch != utp_pkg::CH_RBRACE) set_fail = 1'b1;
					end else begin
						body_chk = 1'b1;
					end
				end
			endcase

			// Hyphen body, braced form indexed one place back
			if (body_chk) begin
				if (q >= utp_pkg::LEN_HYPHEN[utp_pkg::POS_W-1:0]) begin
					set_fail = 1'b1;
				end else if (q == utp_pkg::POS_HYPH_1 || q == utp_pkg::POS_HYPH_2 ||
				             q == utp_pkg::POS_HYPH_3 || q == utp_pkg::POS_HYPH_4) begin
					if (chr.ch != utp_pkg::CH_HYPHEN) set_fail = 1'b1;
				end else if (!hx.is_hex) begin
					set_fail = 1'b1;
				end else begin
					do_shift = 1'b1;
				end
			end
		end

		if (set_fail) upd.failed = 1'b1;
		if (do_shift) {upd.acc_high, upd.acc_low} = {cur.acc_high[utp_pkg::HALF_W-5:0],
		                                            cur.acc_low, hx.value};
		upd.pos = (cur.pos == utp_pkg::POS_MAX) ? cur.pos : cur.pos + 6'd1;
	end

	always_comb begin
		case (upd.form)
			utp_pkg::FORM_PLAIN:  len_ok = (len == utp_pkg::LEN_PLAIN);
			utp_pkg::FORM_HYPHEN: len_ok = (len == utp_pkg::LEN_HYPHEN);
			utp_pkg::FORM_BRACED: len_ok = (len == utp_pkg::LEN_BRACED);
			default:              len_ok = 1'b0;
		endcase
		ok = !upd.failed && len_ok;

		res.valid_res = ok;
		res.uuid_high = ok ? upd.acc_high : '0;
		res.uuid_low  = ok ? upd.acc_low  : '0;

		// Clear for the next string after the final character
		nxt = chr.last ? '0 : upd;
	end

endmodule

/* hdl/uuid_text_parser.sv */
// Top level of the UUID text parser: input stage, parse state and result register.
//
// Usage: send the characters of one UUID string on chars, one request per
// character, with last set on the final one. Plain 32-digit, hyphenated
// 36-character and braced 38-character forms are accepted, hex in either case.
// For each final character one request leaves on result: valid_res and the
// 128-bit value split into uuid_high and uuid_low (both zero when invalid).
// Other characters produce nothing on result.
// A final character passes two register stages on its way to result: the input
// register, then the parse state and result register.
// Throughput: one character per cycle unless a final character waits on a stalled
// result; the parse state updates from the registered character, and the result register frees as it is taken.
// Reset clears the parse state and both stages, so the next character starts a
// new string. When result stalls, a final character waits in the input stage
// and chars drops ready only once that stage is also held; characters that
// are not final keep flowing while an earlier result waits.
module uuid_text_parser (
	input  logic          clk,
	input  logic          arst_n,
	utp_stream_if.sink    chars,
	utp_stream_if.source  result
);

	utp_pkg::char_t        chr_s1;
	logic                  valid_s1;
	utp_pkg::parse_state_t state_q;
	utp_pkg::parse_state_t state_nxt;
	utp_pkg::result_t      res_nxt;
	utp_pkg::result_t      res_q;
	logic                  res_valid_q;
	logic                  out_free;
	logic                  s1_fire;

	assign out_free     = !res_valid_q || result.ready;
	assign s1_fire      = valid_s1 && (!chr_s1.last || out_free);
	assign chars.ready  = !valid_s1 || s1_fire;
	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	utp_step u_step (
		.cur (state_q),
		.chr (chr_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) chr_s1 <= chars.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && chr_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && chr_s1.last) res_q <= res_nxt;
	end

	// A result appears only from a final character leaving the input stage
	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && chr_s1.last))
		else $error("result raised without a final character");

	// An invalid verdict carries a zero value
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.valid_res |-> res_q.uuid_high == '0 && res_q.uuid_low == '0)
		else $error("invalid result with nonzero value");

	// The parse state starts fresh after a final character
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && chr_s1.last |=> state_q.pos == '0 &&
		state_q.form == utp_pkg::FORM_UNKNOWN && !state_q.failed)
		else $error("parse state not cleared after final character");

	// The plain form is only known once the decision place has passed
	a_plain_late: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.form == utp_pkg::FORM_PLAIN |-> state_q.pos > utp_pkg::POS_DECIDE)
		else $error("plain form decided too early");

	// A held final character must not overwrite a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> $stable(res_q))
		else $error("waiting result overwritten");

endmodule

/* test/uuid_text_parser_tb.sv */
// Testbench for the UUID text parser: random and directed strings checked against a predictor.
`timescale 1ns / 100ps

module uuid_text_parser_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [7:0] ASC_0  = "0";
	localparam logic [7:0] ASC_UA = "A";
	localparam logic [7:0] ASC_LA = "a";

	class uuid_scoreboard;
		logic [utp_pkg::POS_W-1:0]  pos;
		logic [1:0]                 form;
		bit                         broken;
		logic [utp_pkg::HALF_W-1:0] acc_hi;
		logic [utp_pkg::HALF_W-1:0] acc_lo;
		utp_pkg::result_t           want_q[$];
		int                         errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			pos    = '0;
			form   = utp_pkg::FORM_UNKNOWN;
			broken = 1'b0;
			acc_hi = '0;
			acc_lo = '0;
		endfunction

		// bit 4 set means the character is not a hex digit
		function logic [4:0] digit_of(logic [7:0] c);
			if (c >= ASC_0 && c <= ASC_0 + 8'd9) return 5'(c - ASC_0);
			if (c >= ASC_UA && c <= ASC_UA + 8'd5) return 5'(c - ASC_UA + 8'd10);
			if (c >= ASC_LA && c <= ASC_LA + 8'd5) return 5'(c - ASC_LA + 8'd10);
			return 5'd16;
		endfunction

		function void shift_in(logic [3:0] d);
			acc_hi = {acc_hi[utp_pkg::HALF_W-5:0], acc_lo[utp_pkg::HALF_W-1 -: 4]};
			acc_lo = {acc_lo[utp_pkg::HALF_W-5:0], d};
		endfunction

		function void body_char(logic [utp_pkg::POS_W-1:0] q, logic [7:0] c);
			logic [4:0] d;
			d = digit_of(c);
			if (q >= utp_pkg::LEN_HYPHEN) begin
				broken = 1'b1;
			end else if (q == utp_pkg::POS_HYPH_1 || q == utp_pkg::POS_HYPH_2 ||
					q == utp_pkg::POS_HYPH_3 || q == utp_pkg::POS_HYPH_4) begin
				if (c != utp_pkg::CH_HYPHEN) broken = 1'b1;
			end else if (d[4]) begin
				broken = 1'b1;
			end else begin
				shift_in(d[3:0]);
			end
		endfunction

		function void note_char(utp_pkg::char_t c);
			logic [4:0]              d;
			logic [utp_pkg::POS_W:0] len;
			bit                      ok;
			utp_pkg::result_t        r;
			d = digit_of(c.ch);
			if (!broken) begin
				if (form == utp_pkg::FORM_UNKNOWN) begin
					if (pos == '0 && c.ch == utp_pkg::CH_LBRACE) begin
						form = utp_pkg::FORM_BRACED;
					end else if (pos == utp_pkg::POS_DECIDE &&
							c.ch == utp_pkg::CH_HYPHEN) begin
						form = utp_pkg::FORM_HYPHEN;
					end else if (d[4]) begin
						broken = 1'b1;
					end else begin
						if (pos == utp_pkg::POS_DECIDE) form = utp_pkg::FORM_PLAIN;
						shift_in(d[3:0]);
					end
				end else if (form == utp_pkg::FORM_PLAIN) begin
					if (pos >= utp_pkg::LEN_PLAIN || d[4]) broken = 1'b1;
					else shift_in(d[3:0]);
				end else if (form == utp_pkg::FORM_HYPHEN) begin
					body_char(pos, c.ch);
				end else if (pos == utp_pkg::POS_RBRACE) begin
					if (c.ch != utp_pkg::CH_RBRACE) broken = 1'b1;
				end else if (pos > utp_pkg::POS_RBRACE) begin
					broken = 1'b1;
				end else begin
					body_char(pos - 1'b1, c.ch);
				end
			end
			len = {1'b0, pos} + 1'b1;
			if (pos != utp_pkg::POS_MAX) pos = pos + 1'b1;
			if (c.last) begin
				ok = !broken &&
					((form == utp_pkg::FORM_PLAIN && len == utp_pkg::LEN_PLAIN) ||
					(form == utp_pkg::FORM_HYPHEN && len == utp_pkg::LEN_HYPHEN) ||
					(form == utp_pkg::FORM_BRACED && len == utp_pkg::LEN_BRACED));
				r.uuid_high = ok ? acc_hi : '0;
				r.uuid_low  = ok ? acc_lo : '0;
				r.valid_res = ok;
				want_q.push_back(r);
				clear();
			end
		endfunction

		function void check_result(utp_pkg::result_t got);
			utp_pkg::result_t want;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: %h %h %b", $time,
					got.uuid_high, got.uuid_low, got.valid_res);
				return;
			end
			want = want_q.pop_front();
			if (got.valid_res !== want.valid_res) begin
				errors++;
				$display("%0t: valid_res expected %b, got %b", $time,
					want.valid_res, got.valid_res);
			end
			if (got.uuid_high !== want.uuid_high) begin
				errors++;
				$display("%0t: uuid_high expected %h, got %h", $time,
					want.uuid_high, got.uuid_high);
			end
			if (got.uuid_low !== want.uuid_low) begin
				errors++;
				$display("%0t: uuid_low expected %h, got %h", $time,
					want.uuid_low, got.uuid_low);
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	utp_stream_if #(.payload_t(utp_pkg::char_t))   chars_if ();
	utp_stream_if #(.payload_t(utp_pkg::result_t)) res_if ();

	uuid_text_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (res_if)
	);

	uuid_scoreboard sb = new();
	logic [7:0]     text[$];
	bit             idle_off;
	int             hold_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[uuid_text_parser] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
	end

	// result side: random stall per request, long hold-off on demand
	initial begin : sink_side
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else begin
				stall = idle_off ? 0 : $urandom_range(0, 11);
				if (stall > 0) begin
					res_if.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
				res_if.ready <= 1'b1;
				do @(posedge clk); while (!res_if.valid && hold_cycles == 0);
				@(negedge clk);
			end
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] d, logic up);
		if (d < 4'd10) return ASC_0 + d;
		return (up ? ASC_UA : ASC_LA) + d - 8'd10;
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 7))
			0, 1, 2: return hex_char(4'($urandom), 1'($urandom));
			3: return utp_pkg::CH_HYPHEN;
			4: return utp_pkg::CH_LBRACE;
			5: return utp_pkg::CH_RBRACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void make_uuid(logic [1:0] f, logic [127:0] v);
		text.delete();
		if (f == utp_pkg::FORM_BRACED) text.push_back(utp_pkg::CH_LBRACE);
		for (int i = 0; i < 32; i++) begin
			if (f != utp_pkg::FORM_PLAIN && (i == 8 || i == 12 || i == 16 || i == 20))
				text.push_back(utp_pkg::CH_HYPHEN);
			text.push_back(hex_char(v[127 - 4 * i -: 4], 1'($urandom)));
		end
		if (f == utp_pkg::FORM_BRACED) text.push_back(utp_pkg::CH_RBRACE);
	endfunction

	function automatic void load(string s);
		text.delete();
		foreach (s[i]) text.push_back(s[i]);
	endfunction

	// called at a falling edge; returns at the falling edge after the last request
	task automatic send_text();
		int gap;
		foreach (text[i]) begin
			gap = idle_off ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				chars_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			chars_if.valid   <= 1'b1;
			chars_if.payload <= '{ch: text[i], last: (i == text.size() - 1)};
			do @(posedge clk); while (!chars_if.ready);
			sb.note_char(chars_if.payload);
			@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [1:0]   forms[3];
		logic [127:0] value;
		int           kind;
		int           idx;
		int           rand_chars;
		int           rand_strings;

		forms            = '{utp_pkg::FORM_PLAIN, utp_pkg::FORM_HYPHEN, utp_pkg::FORM_BRACED};
		rand_chars       = 0;
		rand_strings     = 0;
		idle_off         = 1'b0;
		hold_cycles      = 0;
		arst_n           = 1'b0;
		chars_if.valid   = 1'b0;
		chars_if.payload = '0;
		res_if.ready     = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed strings
		make_uuid(utp_pkg::FORM_PLAIN, '0);
		send_text();
		make_uuid(utp_pkg::FORM_HYPHEN, '1);
		send_text();
		load("{01234567-89AB-cdef-0123-456789abcdef}");
		send_text();
		load("0123456789abcdefABCDEF0123456789");
		send_text();
		load("01234567-89ab-cdef-0123-456789abcdef");
		send_text();
		load("0123456789ab-cdef-0123-456789abcdef");
		send_text();
		load("01234567-89ab-cdef00123-456789abcdef");
		send_text();
		load("01234567-89ab-cdef-0123-456789abcdeg");
		send_text();
		load("{01234567-89ab-cdef-0123-456789abcdef]");
		send_text();
		load("{01234567-89ab-cdef-0123-456789abcdef}}");
		send_text();
		load("0123456789abcdef0123456789abcdef0");
		send_text();
		load("01234567-89ab-cdef-0123-456789abcde");
		send_text();
		load("{01234567}");
		send_text();
		load("abc");
		send_text();
		load("{");
		send_text();
		load("7");
		send_text();
		load("0123456-");
		send_text();
		load("/:@G`g");
		send_text();
		// run the position counter into saturation
		make_uuid(utp_pkg::FORM_PLAIN, '1);
		repeat (38) text.push_back(ASC_0);
		send_text();
		text = '{8'h00};
		send_text();
		text = '{8'hFF, 8'h80};
		send_text();
		wait_drained();

		// hold off results while short strings keep arriving
		idle_off    = 1'b1;
		hold_cycles = 300;
		repeat (40) begin
			text = '{pick_char()};
			send_text();
		end
		make_uuid(utp_pkg::FORM_BRACED, {$urandom, $urandom, $urandom, $urandom});
		send_text();
		wait_drained();
		idle_off = 1'b0;

		while (rand_chars < 600 || rand_strings < 16) begin
			if (rand_strings % 8 == 0) idle_off = ($urandom_range(0, 3) == 0);
			kind  = $urandom_range(0, 9);
			value = {$urandom, $urandom, $urandom, $urandom};
			if (kind <= 7) make_uuid(forms[$urandom_range(0, 2)], value);
			case (kind)
				6: text[$urandom_range(0, text.size() - 1)] = pick_char();
				7: begin
					idx = $urandom_range(0, text.size() - 1);
					case ($urandom_range(0, 2))
						0: text.delete(idx);
						1: text.insert(idx, pick_char());
						default: repeat ($urandom_range(1, 30)) text.push_back(pick_char());
					endcase
				end
				8: begin
					text.delete();
					repeat ($urandom_range(1, 70)) text.push_back(pick_char());
				end
				9: begin
					text.delete();
					if ($urandom_range(0, 1)) text.push_back(utp_pkg::CH_LBRACE);
					repeat ($urandom_range(1, 10))
						text.push_back(hex_char(4'($urandom), 1'($urandom)));
				end
				default: ;
			endcase
			rand_chars += text.size();
			rand_strings++;
			send_text();
		end
		wait_drained();

		if (sb.errors == 0) begin
			$display("[uuid_text_parser] OK");
		end else begin
			$display("[uuid_text_parser] ERROR");
		end
		$finish;
	end

endmodule
